// ===== rtl/mandelbrot_escape_time_assert.svh =====
// Assertion macros shared by the escape-time RTL.
// No dependencies; included inside module bodies after the logic.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// Shared types and constants for the escape-time block.
// No dependencies; used by mbe_ctrl, mbe_dp and the top level.
package mbe_pkg;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] MAX_ITER_RST = 10'd511;

  typedef struct packed {
    logic load;  // capture c, z = c
    logic mul;   // register squares, cross product and range flag
    logic upd;   // z = z*z + c
  } dp_cmd_t;

  typedef struct packed {
    logic escape;  // valid in the cycle after mul
  } dp_sts_t;

endpackage

// ===== rtl/mbe_dp.sv =====
// Datapath: c and z registers, three multipliers, escape test.
// Depends on mbe_pkg; driven by mbe_ctrl through dp_cmd_t.
module mbe_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                          clk,
  input  mbe_pkg::dp_cmd_t              cmd,
  input  logic signed [DATA_WIDTH-1:0]  c_real,
  input  logic signed [DATA_WIDTH-1:0]  c_imag,
  output mbe_pkg::dp_sts_t              sts
);
  import mbe_pkg::*;

  localparam int MW = FRAC_BITS + 1;
  localparam int PW = 2 * MW;
  localparam int ZW = ((DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4) + 2;
  localparam int SW = FRAC_BITS + 2;

  logic signed [DATA_WIDTH-1:0] cr_r, ci_r;
  logic signed [ZW-1:0]         zr_r, zi_r, zr_nxt, zi_nxt;
  logic        [ZW-1:0]         zr_abs, zi_abs;
  logic        [PW-1:0]         prr_r, pii_r, pri_r;
  logic                         neg_r, big_r, big;
  logic        [SW-1:0]         sr, si;
  logic        [SW:0]           sum;
  logic signed [PW:0]           p_s, cross_s;

  assign zr_abs = zr_r[ZW-1] ? ZW'(-zr_r) : zr_r;
  assign zi_abs = zi_r[ZW-1] ? ZW'(-zi_r) : zi_r;
  assign big    = (|zr_abs[ZW-1:MW]) | (|zi_abs[ZW-1:MW]);

  assign sr  = prr_r[PW-1:FRAC_BITS];
  assign si  = pii_r[PW-1:FRAC_BITS];
  assign sum = {1'b0, sr} + {1'b0, si};

  // floor of the signed doubled cross product
  assign p_s     = neg_r ? -$signed({1'b0, pri_r}) : $signed({1'b0, pri_r});
  assign cross_s = p_s >>> (FRAC_BITS - 1);

  assign zr_nxt = ZW'($signed({1'b0, sr})) - ZW'($signed({1'b0, si})) + ZW'(cr_r);
  assign zi_nxt = ZW'(cross_s) + ZW'(ci_r);

  assign sts.escape = big_r | sum[SW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r <= c_real;
      ci_r <= c_imag;
      zr_r <= ZW'(c_real);
      zi_r <= ZW'(c_imag);
    end else if (cmd.upd) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
    end
    if (cmd.mul) begin
      prr_r <= zr_abs[MW-1:0] * zr_abs[MW-1:0];
      pii_r <= zi_abs[MW-1:0] * zi_abs[MW-1:0];
      pri_r <= zr_abs[MW-1:0] * zi_abs[MW-1:0];
      neg_r <= zr_r[ZW-1] ^ zi_r[ZW-1];
      big_r <= big;
    end
  end

endmodule

// ===== rtl/mbe_ctrl.sv =====
// Controller: iteration FSM, limit register, count and output register.
// Depends on mbe_pkg and mandelbrot_escape_time_assert.svh.
module mbe_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mbe_pkg::CNT_W-1:0] cfg_max_iterations,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mbe_pkg::CNT_W-1:0] out_iteration_count,
  output mbe_pkg::dp_cmd_t          cmd,
  input  mbe_pkg::dp_sts_t          sts
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_UPDATE, S_DONE} state_t;

  state_t           st_r;
  logic [CNT_W-1:0] max_iter_r, count_r, out_count_r;
  logic             out_valid_r;

  assign cfg_ready           = 1'b1;
  assign in_ready            = (st_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;

  always_comb begin
    cmd.load = in_valid && (st_r == S_IDLE);
    cmd.mul  = (st_r == S_CHECK) && (count_r < max_iter_r);
    cmd.upd  = (st_r == S_UPDATE) && !sts.escape;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      max_iter_r  <= MAX_ITER_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) max_iter_r <= cfg_max_iterations;
      if ((st_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_count_r <= count_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            count_r <= '0;
            st_r    <= S_CHECK;
          end
        end
        S_CHECK: begin
          st_r <= (count_r < max_iter_r) ? S_UPDATE : S_DONE;
        end
        S_UPDATE: begin
          if (sts.escape) begin
            st_r <= S_DONE;
          end else begin
            count_r <= count_r + 1'b1;
            st_r    <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`include "mandelbrot_escape_time_assert.svh"

  `MBE_ASSERT_IMP(a_upd_below_limit, clk, rst_n, cmd.upd, count_r < max_iter_r, "update past limit")
  `MBE_ASSERT_IMP(a_count_in_range, clk, rst_n, st_r != S_IDLE, count_r <= max_iter_r, "count over limit")
  `MBE_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, st_r == S_CHECK, "accept did not start")
  `MBE_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(st_r) == S_DONE, "stray result")

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit, top level.
// Depends on mbe_pkg, mbe_ctrl and mbe_dp.
//
// Input channel in_*: one point c (in_c_real, in_c_imag, signed fixed
// point with FRAC_BITS fraction bits) per valid/ready transfer.
// Output channel out_*: one out_iteration_count per point, in order.
// Config channel cfg_*: cfg_max_iterations sets the iteration limit
// (reset 511); always ready, write only while the block is idle.
// An iteration passes through S_CHECK, where the three multipliers
// register their products, and S_UPDATE, which does the escape test
// and z update. A point keeps the block busy from transfer until its
// result is in the output register, whether the limit stops it or
// it escapes, and the next point is taken no earlier.
// A finished result sits in the output register; the next point is
// taken meanwhile, and a stalled receiver only holds the block once a
// second result is ready.
// Reset clears the controller and output valid and restores the limit.
module mandelbrot_escape_time #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbe_pkg::CNT_W-1:0]     cfg_max_iterations,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  in_c_real,
  input  logic signed [DATA_WIDTH-1:0]  in_c_imag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mbe_pkg::CNT_W-1:0]     out_iteration_count
);
  import mbe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbe_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_iterations  (cfg_max_iterations),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  mbe_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .c_real (in_c_real),
    .c_imag (in_c_imag),
    .sts    (sts)
  );

endmodule

// ===== sim/mandelbrot_escape_time_tb.sv =====
// Self-checking testbench for mandelbrot_escape_time: directed points, then random
// points under several iteration limits, with bursty input and a stalling receiver.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.
module mandelbrot_escape_time_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 28;
  localparam int CNT_W = mbe_pkg::CNT_W;
  localparam longint UNIT = 64'sd1 <<< FRAC_W;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 50;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh1000_0000;
  localparam logic signed [DATA_W-1:0] Q_TWO = 32'sh2000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] PREDICT = -32'sd1;
  localparam logic signed [31:0] NO_ITER = 32'sd0;
  localparam logic signed [31:0] RST_LIMIT = {22'd0, mbe_pkg::MAX_ITER_RST};
  localparam int DIR_ROWS = 20;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic signed [31:0]       want;
  } point_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;

  // want = PREDICT: count comes from escape_count
  point_row_t dir_points [DIR_ROWS] = '{
    {32'sd0, 32'sd0, RST_LIMIT},
    {Q_MAX, Q_MAX, NO_ITER},
    {Q_MIN, Q_MIN, NO_ITER},
    {Q_MAX, Q_MIN, NO_ITER},
    {Q_MIN, 32'sd0, NO_ITER},
    {Q_TWO, 32'sd0, NO_ITER},
    {32'sd0, -Q_TWO, NO_ITER},
    {-Q_TWO, 32'sd0, NO_ITER},
    {Q_TWO - 32'sd1, Q_TWO - 32'sd1, NO_ITER},
    {Q_ONE, 32'sd0, 32'sd1},
    {-Q_ONE, 32'sd0, RST_LIMIT},
    {32'sd0, Q_ONE, PREDICT},
    {-Q_ONE, Q_ONE, PREDICT},
    {-Q_TWO + 32'sd1, 32'sd0, PREDICT},
    {Q_ONE / 4, 32'sd0, PREDICT},
    {Q_ONE / 4 + 32'sd1, 32'sd0, PREDICT},
    {-(3 * Q_ONE / 4), Q_ONE / 16, PREDICT},
    {Q_ONE / 2, Q_ONE / 2, PREDICT},
    {32'sd1, -32'sd1, PREDICT},
    {-(Q_ONE + Q_ONE / 2), 32'sd0, PREDICT}
  };

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_max_iterations;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_c_real;
  logic signed [DATA_W-1:0] in_c_imag;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CNT_W-1:0]         out_iteration_count;

  logic signed [31:0] in_fixed;
  logic [CNT_W-1:0]   iter_limit;
  logic [CNT_W-1:0]   pending_counts [$];
  logic [CNT_W-1:0]   want_count;
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  rx_mode_t           rx_mode = RX_OPEN;
  int                 rx_left = 0;
  int                 rx_phase = 0;

  mandelbrot_escape_time #(
    .DATA_WIDTH(DATA_W),
    .FRAC_BITS (FRAC_W)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_iterations (cfg_max_iterations),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_c_real          (in_c_real),
    .in_c_imag          (in_c_imag),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_iteration_count(out_iteration_count)
  );

  always #5 clk = ~clk;

  // z = z*z + c while |z|^2 < 4, products floored
  function automatic logic [CNT_W-1:0] escape_count(input logic signed [DATA_W-1:0] cr, ci,
                                                    input logic [CNT_W-1:0] limit);
    longint zr, zi, sr, si, cr_w, ci_w;
    int n;
    cr_w = cr;
    ci_w = ci;
    zr = cr_w;
    zi = ci_w;
    n = 0;
    while (n < int'(limit)) begin
      if (zr >= 2 * UNIT || zr <= -2 * UNIT || zi >= 2 * UNIT || zi <= -2 * UNIT) break;
      sr = (zr * zr) >>> FRAC_W;
      si = (zi * zi) >>> FRAC_W;
      if (sr + si >= 4 * UNIT) break;
      zi = ((zr * zi) >>> (FRAC_W - 1)) + ci_w;
      zr = sr - si + cr_w;
      n++;
    end
    return n[CNT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_point(input logic signed [DATA_W-1:0] re, im,
                            input logic signed [31:0] want);
    @(negedge clk);
    in_valid = 1'b1;
    in_c_real = re;
    in_c_imag = im;
    in_fixed = want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] limit);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_max_iterations = limit;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic pick_point(output logic signed [DATA_W-1:0] re, im);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      re = -(Q_TWO + Q_ONE / 4) + $urandom_range(3 * Q_ONE);
      im = -(Q_ONE + Q_ONE / 2) + $urandom_range(3 * Q_ONE);
    end else if (sel < 65) begin
      re = -Q_TWO + $urandom_range(Q_TWO + Q_ONE / 4);
      im = $urandom_range(0, 65535) - 32768;
    end else if (sel < 75) begin
      // quarter-unit lattice hits |z|^2 == 4 exactly
      re = ($urandom_range(0, 20) - 10) * (Q_ONE / 4);
      im = ($urandom_range(0, 20) - 10) * (Q_ONE / 4);
    end else begin
      re = $urandom();
      im = $urandom();
    end
  endtask

  task automatic run_points(input int total);
    logic signed [DATA_W-1:0] re, im;
    int burst, sel, k;
    k = 0;
    while (k < total) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && k < total; b++) begin
        pick_point(re, im);
        send_point(re, im, PREDICT);
        k++;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) pause_sender(0);
      else if (sel < 9) pause_sender($urandom_range(1, 6));
      else pause_sender($urandom_range(7, 60));
    end
    pause_sender(1);
    wait_drained();
  endtask

  // scoreboard: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      iter_limit = mbe_pkg::MAX_ITER_RST;
    end else begin
      if (cfg_valid && cfg_ready) iter_limit = cfg_max_iterations;
      if (in_valid && in_ready) begin
        if (in_fixed == PREDICT)
          pending_counts.push_back(escape_count(in_c_real, in_c_imag, iter_limit));
        else
          pending_counts.push_back(in_fixed[CNT_W-1:0]);
      end
      if (out_valid && out_ready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, count %0d",
                                    out_iteration_count));
        end else begin
          want_count = pending_counts.pop_front();
          if (out_iteration_count !== want_count)
            report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                      out_iteration_count, want_count));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   out_ready = 1'b1;
      RX_COIN:   out_ready = ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready = ($urandom_range(0, 7) == 0);
      default:   out_ready = ((rx_phase % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mandelbrot_escape_time_tb failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_max_iterations = '0;
    in_valid = 1'b0;
    in_c_real = '0;
    in_c_imag = '0;
    in_fixed = PREDICT;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed points at the reset limit
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_point(dir_points[i].re, dir_points[i].im, dir_points[i].want);
      pause_sender($urandom_range(0, 2));
    end
    pause_sender(1);
    wait_drained();

    write_limit(10'd1023);
    run_points(15);
    write_limit(10'd1);
    run_points(60);
    write_limit(10'd0);
    run_points(30);
    repeat (20) begin
      if ($urandom_range(0, 4) != 0) write_limit(CNT_W'($urandom_range(2, 64)));
      else write_limit(CNT_W'($urandom_range(65, 200)));
      run_points(40);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("mandelbrot_escape_time_tb passed");
    else
      $display("mandelbrot_escape_time_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_dp.sv
rtl/mbe_ctrl.sv
rtl/mandelbrot_escape_time.sv
sim/mandelbrot_escape_time_tb.sv
